// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// check on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hdl/ftgc_pkg.sv =====
// Shared types and constants for the force/torque gravity compensation block.
// No dependencies.
package ftgc_pkg;

    localparam int IN_TDATA_W  = 288;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVER_ARM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE     = 3'd4;

    localparam logic [1:0] FRAME_SENSOR     = 2'd0;
    localparam logic [1:0] FRAME_BASE       = 2'd1;
    localparam logic [1:0] FRAME_BASE_LEVER = 2'd2;

    typedef struct packed {
        logic adv_prod;
        logic adv_sum;
    } t_rot_ctl;

endpackage

// ===== hdl/ftgc_rotate.sv =====
// Two-stage rotation of a three-vector by a Q1.14 matrix: products, then sum and round.
// Depends on ftgc_pkg for the stage advance struct.
module ftgc_rotate
    import ftgc_pkg::*;
#(
    parameter int W  = 16,
    parameter int VW = 21,
    parameter int OW = 26
) (
    input  logic                     i_clk,
    input  t_rot_ctl                 i_ctl,
    input  logic [2:0][2:0][W-1:0]   i_rot,
    input  logic [2:0][VW-1:0]       i_vec,
    output logic [2:0][OW-1:0]       o_vec
);

    localparam int PW = W + VW;
    localparam int SW = PW + 3;
    localparam logic signed [SW-1:0] HALF = SW'(32'sd8192);

    logic [2:0][2:0][PW-1:0] r_prod;
    logic [2:0][OW-1:0]      r_out;
    logic signed [SW-1:0]    w_sum [3];

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_prod) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= $signed(i_rot[i][j]) * $signed(i_vec[j]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = SW'($signed(r_prod[i][0])) + SW'($signed(r_prod[i][1]))
                     + SW'($signed(r_prod[i][2])) + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_sum) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= w_sum[i][OW+13:14];
            end
        end
    end

    assign o_vec = r_out;

endmodule

// ===== hdl/ft_gravity_compensation.sv =====
// Top level of the force/torque gravity compensation pipeline.
// Depends on ftgc_pkg and ftgc_rotate.
//
//  channel   | direction | handshake                     | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | wrench, rotation rows, position
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | compensated wrench
//  cfg       | in        | i_cfg_wr_en                   | i_cfg_index, i_cfg_data
//
// Seven register stages; one item per cycle sustained while m_axis_tready stays high.
// The multiplier stages (gravity, cross terms, rotation, lever term) set the depth.
// Reset clears stage valid bits and configuration registers; payload is not reset.
// Each stage holds while its successor is full and stalled; bubbles are squeezed out.
module ft_gravity_compensation
    import ftgc_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z (16 each),
    // rot_row0, rot_row1, rot_row2, sensor_position (48 each)
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_force_x, out_force_y, out_force_z, out_torque_x, out_torque_y, out_torque_z
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int W   = COMPONENT_WIDTH;
    localparam int GPW = 16 + W;
    localparam int GW  = W + 3;
    localparam int FW  = W + 5;
    localparam int CPW = GW + W;
    localparam int CW  = CPW + 1;
    localparam int TW  = CW - 8;
    localparam int RFW = 2 * W - 6;
    localparam int RTW = W + TW - 11;
    localparam int PCW = W + RFW;
    localparam int XW  = 3 * W - 8;

    localparam logic signed [XW-1:0] SAT_HI = XW'(32'sd32767);
    localparam logic signed [XW-1:0] SAT_LO = XW'(-32'sd32768);

    function automatic logic [W-1:0] comp(input logic [47:0] v, input int idx);
        logic [63:0] e;
        e = {16'd0, v};
        return e[idx*W +: W];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [XW-1:0] v);
        logic [15:0] res;
        if (v > SAT_HI) begin
            res = 16'h7fff;
        end else if (v < SAT_LO) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // configuration
    logic [15:0] r_grav;
    logic [47:0] r_force_off;
    logic [47:0] r_torque_off;
    logic [47:0] r_lever;
    logic [1:0]  r_frame_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav       <= '0;
            r_force_off  <= '0;
            r_torque_off <= '0;
            r_lever      <= '0;
            r_frame_mode <= FRAME_SENSOR;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_GRAVITY_WEIGHT: r_grav       <= i_cfg_data[15:0];
                CFG_FORCE_OFFSET:   r_force_off  <= i_cfg_data;
                CFG_TORQUE_OFFSET:  r_torque_off <= i_cfg_data;
                CFG_LEVER_ARM:      r_lever      <= i_cfg_data;
                CFG_FRAME_MODE:     r_frame_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stage valids and readies
    logic [7:1] r_vld;
    logic [8:1] w_rdy;
    logic [7:1] w_vin;

    always_comb begin
        w_rdy[8] = m_axis_tready;
        for (int k = 7; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_vin = {r_vld[6:1], s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= 7; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign s_axis_tready = w_rdy[1];

    // stage 1: unpack, gravity products
    logic [2:0][2:0][W-1:0] w_rot;
    logic [2:0][W-1:0]      w_pos;
    logic [2:0][W-1:0]      w_fo;
    logic [2:0][W-1:0]      w_to;
    logic [2:0][W-1:0]      w_lv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_rot[i][j] = comp(s_axis_tdata[96 + 48*i +: 48], j);
            end
            w_pos[i] = comp(s_axis_tdata[240 +: 48], i);
            w_fo[i]  = comp(r_force_off, i);
            w_to[i]  = comp(r_torque_off, i);
            w_lv[i]  = comp(r_lever, i);
        end
    end

    logic [2:0][GPW-1:0]    r_s1_gp;
    logic [5:0][15:0]       r_s1_wr;
    logic [2:0][2:0][W-1:0] r_s1_rot;
    logic [2:0][W-1:0]      r_s1_pos;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_gp[i] <= $signed(r_grav) * $signed(w_rot[2][i]);
            end
            r_s1_wr  <= s_axis_tdata[95:0];
            r_s1_rot <= w_rot;
            r_s1_pos <= w_pos;
        end
    end

    // stage 2: round gravity, force sum, cross products
    logic signed [GPW:0] w_gs [3];
    logic [2:0][GW-1:0]  w_gv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_gs[i] = (GPW+1)'($signed(r_s1_gp[i])) + (GPW+1)'(32'sd8192);
            w_gv[i] = w_gs[i][GPW:14];
        end
    end

    logic [2:0][FW-1:0]     r_s2_f;
    logic [5:0][CPW-1:0]    r_s2_cp;
    logic [2:0][15:0]       r_s2_t;
    logic [2:0][2:0][W-1:0] r_s2_rot;
    logic [2:0][W-1:0]      r_s2_pos;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_f[i] <= FW'($signed(r_s1_wr[i])) + FW'($signed(w_gv[i]))
                           - FW'($signed(w_fo[i]));
            end
            r_s2_cp[0] <= $signed(w_gv[2]) * $signed(w_lv[1]);
            r_s2_cp[1] <= $signed(w_gv[1]) * $signed(w_lv[2]);
            r_s2_cp[2] <= $signed(w_gv[0]) * $signed(w_lv[2]);
            r_s2_cp[3] <= $signed(w_gv[2]) * $signed(w_lv[0]);
            r_s2_cp[4] <= $signed(w_gv[1]) * $signed(w_lv[0]);
            r_s2_cp[5] <= $signed(w_gv[0]) * $signed(w_lv[1]);
            r_s2_t   <= r_s1_wr[5:3];
            r_s2_rot <= r_s1_rot;
            r_s2_pos <= r_s1_pos;
        end
    end

    // stage 3: cross difference, round, torque sum
    logic signed [CW-1:0] w_c  [3];
    logic signed [CW:0]   w_cs [3];
    logic [2:0][CW-10:0]  w_rc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c[i]  = CW'($signed(r_s2_cp[2*i])) - CW'($signed(r_s2_cp[2*i+1]));
            w_cs[i] = (CW+1)'(w_c[i]) + (CW+1)'(32'sd512);
            w_rc[i] = w_cs[i][CW:10];
        end
    end

    logic [2:0][FW-1:0]     r_s3_f;
    logic [2:0][TW-1:0]     r_s3_t;
    logic [2:0][2:0][W-1:0] r_s3_rot;
    logic [2:0][W-1:0]      r_s3_pos;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_t[i] <= TW'($signed(r_s2_t[i])) + TW'($signed(w_rc[i]))
                           - TW'($signed(w_to[i]));
            end
            r_s3_f   <= r_s2_f;
            r_s3_rot <= r_s2_rot;
            r_s3_pos <= r_s2_pos;
        end
    end

    // stages 4 and 5: rotation into the base frame
    t_rot_ctl            w_rot_ctl;
    logic [2:0][RFW-1:0] w_rf;
    logic [2:0][RTW-1:0] w_rt;

    assign w_rot_ctl.adv_prod = w_rdy[4];
    assign w_rot_ctl.adv_sum  = w_rdy[5];

    ftgc_rotate #(
        .W  (W),
        .VW (FW),
        .OW (RFW)
    ) u_rot_force (
        .i_clk (i_clk),
        .i_ctl (w_rot_ctl),
        .i_rot (r_s3_rot),
        .i_vec (r_s3_f),
        .o_vec (w_rf)
    );

    ftgc_rotate #(
        .W  (W),
        .VW (TW),
        .OW (RTW)
    ) u_rot_torque (
        .i_clk (i_clk),
        .i_ctl (w_rot_ctl),
        .i_rot (r_s3_rot),
        .i_vec (r_s3_t),
        .o_vec (w_rt)
    );

    logic [2:0][FW-1:0] r_s4_f;
    logic [2:0][TW-1:0] r_s4_t;
    logic [2:0][W-1:0]  r_s4_pos;
    logic [2:0][FW-1:0] r_s5_f;
    logic [2:0][TW-1:0] r_s5_t;
    logic [2:0][W-1:0]  r_s5_pos;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s4_f   <= r_s3_f;
            r_s4_t   <= r_s3_t;
            r_s4_pos <= r_s3_pos;
        end
        if (w_rdy[5]) begin
            r_s5_f   <= r_s4_f;
            r_s5_t   <= r_s4_t;
            r_s5_pos <= r_s4_pos;
        end
    end

    // stage 6: lever products p x rf
    logic [5:0][PCW-1:0] r_s6_pc;
    logic [2:0][RFW-1:0] r_s6_rf;
    logic [2:0][RTW-1:0] r_s6_rt;
    logic [2:0][FW-1:0]  r_s6_f;
    logic [2:0][TW-1:0]  r_s6_t;

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_s6_pc[0] <= $signed(r_s5_pos[1]) * $signed(w_rf[2]);
            r_s6_pc[1] <= $signed(r_s5_pos[2]) * $signed(w_rf[1]);
            r_s6_pc[2] <= $signed(r_s5_pos[2]) * $signed(w_rf[0]);
            r_s6_pc[3] <= $signed(r_s5_pos[0]) * $signed(w_rf[2]);
            r_s6_pc[4] <= $signed(r_s5_pos[0]) * $signed(w_rf[1]);
            r_s6_pc[5] <= $signed(r_s5_pos[1]) * $signed(w_rf[0]);
            r_s6_rf <= w_rf;
            r_s6_rt <= w_rt;
            r_s6_f  <= r_s5_f;
            r_s6_t  <= r_s5_t;
        end
    end

    // stage 7: lever term, frame select, saturate
    logic signed [PCW:0]   w_pd  [3];
    logic signed [PCW+1:0] w_ps  [3];
    logic [2:0][PCW-7:0]   w_pr;
    logic signed [XW-1:0]  w_rt2 [3];
    logic signed [XW-1:0]  w_fs  [3];
    logic signed [XW-1:0]  w_ts  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pd[i]  = (PCW+1)'($signed(r_s6_pc[2*i])) - (PCW+1)'($signed(r_s6_pc[2*i+1]));
            w_ps[i]  = (PCW+2)'(w_pd[i]) + (PCW+2)'(32'sd128);
            w_pr[i]  = w_ps[i][PCW+1:8];
            w_rt2[i] = XW'($signed(r_s6_rt[i])) + XW'($signed(w_pr[i]));
            unique case (r_frame_mode)
                FRAME_BASE: begin
                    w_fs[i] = XW'($signed(r_s6_rf[i]));
                    w_ts[i] = XW'($signed(r_s6_rt[i]));
                end
                FRAME_BASE_LEVER: begin
                    w_fs[i] = XW'($signed(r_s6_rf[i]));
                    w_ts[i] = w_rt2[i];
                end
                default: begin
                    w_fs[i] = XW'($signed(r_s6_f[i]));
                    w_ts[i] = XW'($signed(r_s6_t[i]));
                end
            endcase
        end
    end

    logic [5:0][15:0] r_s7_out;

    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            for (int i = 0; i < 3; i++) begin
                r_s7_out[i]     <= sat16(w_fs[i]);
                r_s7_out[3 + i] <= sat16(w_ts[i]);
            end
        end
    end

    assign m_axis_tvalid = r_vld[7];
    assign m_axis_tdata  = r_s7_out;

endmodule

// ===== hdl/ftgc_checker.sv =====
// Port-level checks for the gravity compensation top level, bound to it below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ftgc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    `ASSERT_CLK_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output item changed")
    `ASSERT_CLK(a_ready_flow, m_axis_tready |-> s_axis_tready, "input stalled while output flows")
    `ASSERT_CLK(a_ready_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with output empty")

endmodule

bind ft_gravity_compensation ftgc_checker u_ftgc_checker (.*);
